### src/nnsd_pkg.sv
// Shared constants, types and command/status structures for the nearest neighbor search.
package nnsd_pkg;

	localparam int MAX_ENTRIES    = 64;
	localparam int MAX_DIMENSIONS = 64;

	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int DW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
	localparam int AW = (MAX_ENTRIES * MAX_DIMENSIONS > 1) ?
		$clog2(MAX_ENTRIES * MAX_DIMENSIONS) : 1;

	localparam int CFG_W  = 7;
	localparam int DIST_W = 40;
	localparam int IDX_W  = 6;
	localparam int VAL_W  = 16;

	localparam logic REG_ENTRY_COUNT     = 1'b0;
	localparam logic REG_DIMENSION_COUNT = 1'b1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic [EW-1:0] entry_t;
	typedef logic [DW-1:0] comp_t;

	typedef struct packed {
		logic   accept;
		logic   issue;
		entry_t entry;
		comp_t  comp;
		logic   first_comp;
		logic   last_comp;
		logic   first_entry;
		logic   last_entry;
		logic   load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic   search_req;
		entry_t last_entry;
		comp_t  last_comp;
		logic   done;
		logic   out_free;
	} dp_status_t;

endpackage

### src/nnsd_ctrl.sv
// Controller state machine that sequences the distance search over entries and components.
module nnsd_ctrl
	import nnsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	state_t state_q;
	entry_t entry_q;
	comp_t  comp_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd             = '0;
		cmd.accept      = in_valid && in_ready;
		cmd.issue       = (state_q == ST_RUN);
		cmd.entry       = entry_q;
		cmd.comp        = comp_q;
		cmd.first_comp  = (comp_q == '0);
		cmd.last_comp   = (comp_q == status.last_comp);
		cmd.first_entry = (entry_q == '0);
		cmd.last_entry  = (entry_q == status.last_entry);
		cmd.load_out    = (state_q == ST_HOLD) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_q <= '0;
			comp_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					entry_q <= '0;
					comp_q  <= '0;
					if (cmd.accept && status.search_req) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.last_comp) begin
						comp_q <= '0;
						if (cmd.last_entry) begin
							state_q <= ST_DRAIN;
						end else begin
							entry_q <= entry_q + 1'b1;
						end
					end else begin
						comp_q <= comp_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (status.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/nnsd_dp.sv
// Datapath: reference and query storage, configuration, distance pipeline and result register.
module nnsd_dp
	import nnsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic                   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_command,
	input  logic [IDX_W-1:0]       in_entry_index,
	input  logic [IDX_W-1:0]       in_component_index,
	input  logic signed [VAL_W-1:0] in_component_value,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DIST_W-1:0]      out_least_distance,
	output logic [IDX_W-1:0]       out_nearest_index
);

	logic [CFG_W-1:0] entry_count_q;
	logic [CFG_W-1:0] dimension_count_q;

	logic [VAL_W-1:0] ref_mem [MAX_ENTRIES*MAX_DIMENSIONS];
	logic [VAL_W-1:0] query_mem [MAX_DIMENSIONS];
	logic [MAX_DIMENSIONS-1:0] query_valid_q;

	entry_t last_entry;
	comp_t  last_comp;
	logic   load_ok;
	logic   query_ok;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	logic                    v_s1, v_s2, v_s3;
	logic                    fc_s1, fc_s2, fc_s3;
	logic                    lc_s1, lc_s2, lc_s3;
	logic                    fe_s1, fe_s2, fe_s3, fe_s4;
	logic                    le_s1, le_s2, le_s3, le_s4;
	entry_t                  e_s1, e_s2, e_s3, e_s4;
	logic [VAL_W-1:0]        ref_s1;
	logic [VAL_W-1:0]        qry_s1;
	logic signed [VAL_W:0]   diff_s2;
	logic [VAL_W-1:0]        mag;
	logic [2*VAL_W-1:0]      sq_s3;
	logic [DIST_W-1:0]       acc_q;
	logic [DIST_W:0]         acc_sum;
	logic                    fin_s4;
	logic                    done_s5;
	logic [DIST_W-1:0]       best_q;
	entry_t                  best_idx_q;
	logic                    out_valid_q;
	logic [DIST_W-1:0]       out_dist_q;
	logic [IDX_W-1:0]        out_idx_q;

	always_comb begin
		last_entry = EW'(((entry_count_q == '0) ? 1 :
			((int'(entry_count_q) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count_q))) - 1);
		last_comp = DW'(((dimension_count_q == '0) ? 1 :
			((int'(dimension_count_q) > MAX_DIMENSIONS) ?
			MAX_DIMENSIONS : int'(dimension_count_q))) - 1);
	end

	assign load_ok  = (int'(in_entry_index) < MAX_ENTRIES) &&
		(int'(in_component_index) < MAX_DIMENSIONS);
	assign query_ok = (int'(in_component_index) < MAX_DIMENSIONS);
	assign wr_addr  = AW'(int'(in_entry_index) * MAX_DIMENSIONS + int'(in_component_index));
	assign rd_addr  = AW'(int'(cmd.entry) * MAX_DIMENSIONS + int'(cmd.comp));

	assign status.search_req = (in_command == CMD_QUERY) && query_ok &&
		(int'(in_component_index) == int'(last_comp));
	assign status.last_entry = last_entry;
	assign status.last_comp  = last_comp;
	assign status.done       = done_s5;
	assign status.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q     <= CFG_W'(64);
			dimension_count_q <= CFG_W'(64);
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ENTRY_COUNT:     entry_count_q     <= cfg_data;
				REG_DIMENSION_COUNT: dimension_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (in_command == CMD_LOAD) && load_ok) begin
			ref_mem[wr_addr] <= in_component_value;
		end
		ref_s1 <= ref_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (in_command == CMD_QUERY) && query_ok) begin
			query_mem[DW'(in_component_index)] <= in_component_value;
		end
		qry_s1 <= query_valid_q[cmd.comp] ? query_mem[cmd.comp] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_valid_q <= '0;
		end else if (cmd.accept && (in_command == CMD_QUERY) && query_ok) begin
			query_valid_q[DW'(in_component_index)] <= 1'b1;
		end
	end

	assign mag     = diff_s2[VAL_W] ? VAL_W'(-diff_s2) : VAL_W'(diff_s2);
	assign acc_sum = {1'b0, acc_q} + (DIST_W+1)'(sq_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			fin_s4  <= 1'b0;
			done_s5 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			fin_s4  <= v_s3 && lc_s3;
			done_s5 <= fin_s4 && le_s4;
		end
	end

	always_ff @(posedge clk) begin
		fc_s1 <= cmd.first_comp;
		lc_s1 <= cmd.last_comp;
		fe_s1 <= cmd.first_entry;
		le_s1 <= cmd.last_entry;
		e_s1  <= cmd.entry;

		fc_s2   <= fc_s1;
		lc_s2   <= lc_s1;
		fe_s2   <= fe_s1;
		le_s2   <= le_s1;
		e_s2    <= e_s1;
		diff_s2 <= {qry_s1[VAL_W-1], qry_s1} - {ref_s1[VAL_W-1], ref_s1};

		fc_s3 <= fc_s2;
		lc_s3 <= lc_s2;
		fe_s3 <= fe_s2;
		le_s3 <= le_s2;
		e_s3  <= e_s2;
		sq_s3 <= mag * mag;

		fe_s4 <= fe_s3;
		le_s4 <= le_s3;
		e_s4  <= e_s3;
		if (v_s3) begin
			if (fc_s3) begin
				acc_q <= DIST_W'(sq_s3);
			end else if (acc_sum[DIST_W]) begin
				acc_q <= '1;
			end else begin
				acc_q <= acc_sum[DIST_W-1:0];
			end
		end

		if (fin_s4 && (fe_s4 || (acc_q < best_q))) begin
			best_q     <= acc_q;
			best_idx_q <= e_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_dist_q <= best_q;
			out_idx_q  <= IDX_W'(best_idx_q);
		end
	end

	assign out_valid          = out_valid_q;
	assign out_least_distance = out_dist_q;
	assign out_nearest_index  = out_idx_q;

endmodule

### src/nearest_neighbor_sq_distance.sv
// Top level of the nearest neighbor search by squared Euclidean distance.
//
// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   tuser command, tdata entry/component/value
// m_*      out        m_tvalid/m_tready   tdata least_distance, nearest_index
// cfg_*    in         cfg_wen             cfg_index, cfg_data
//
// A load or a query transaction that starts no search leaves the controller idle.
// The final query component starts a search that reads each configured entry and component
// in turn through the single reference memory read port, then drains the pipeline and loads the result.
// s_tready is low while a search runs; the result register lets new transactions in
// while a finished result waits on m_tready. No clearing pass follows reset.
module nearest_neighbor_sq_distance
	import nnsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,  // command
	input  logic [31:0] s_tdata,  // entry_index, component_index, component_value, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // least_distance, nearest_index, zero pad
);

	ctrl_cmd_t           cmd;
	dp_status_t          status;
	logic [DIST_W-1:0]   least_distance;
	logic [IDX_W-1:0]    nearest_index;

	nnsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	nnsd_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_wen            (cfg_wen),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_command         (s_tuser),
		.in_entry_index     (s_tdata[5:0]),
		.in_component_index (s_tdata[11:6]),
		.in_component_value (s_tdata[27:12]),
		.cmd                (cmd),
		.status             (status),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.out_least_distance (least_distance),
		.out_nearest_index  (nearest_index)
	);

	assign m_tdata = {2'b00, nearest_index, least_distance};

`ifndef SYNTHESIS
	a_done_not_while_issuing: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> !cmd.issue)
		else $error("search completion reported while components are still issued");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> m_tvalid)
		else $error("result load did not raise m_tvalid");

	a_issue_stops_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && cmd.last_comp && cmd.last_entry |=> !cmd.issue)
		else $error("issue continued past the last entry and component");

	a_no_accept_while_issuing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !s_tready)
		else $error("input ready while a search is running");
`endif

endmodule
